// ===== hw/rtl/cbb_pkg.sv =====
// Shared types, constants and helpers for the clipped texture block blitter.
// No dependencies; every other file of the block imports this package.
package cbb_pkg;

  localparam int unsigned MAX_BLOCK_SIZE = 8;
  localparam int unsigned CNT_W          = 4;   // holds 0..MAX_BLOCK_SIZE
  localparam int unsigned COORD_W        = 13;  // signed block corner
  localparam int unsigned SCREEN_W       = 12;
  localparam int unsigned STRIDE_W       = 14;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned FIX_W          = 32;  // 16.16 coordinates
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned TEX_LOG2       = 7;   // 128x128 texture
  localparam int unsigned IDX_W          = 2 * TEX_LOG2;
  localparam int unsigned ROW_OFF_W      = SCREEN_W + STRIDE_W;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned QDEPTH         = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_ROW_STRIDE    = 3'd2,
    REG_FRAME_BASE    = 3'd3,
    REG_WIDE_PIXELS   = 3'd4
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [STRIDE_W-1:0] row_stride;
    logic [ADDR_W-1:0]   frame_base;
    logic                wide_pixels;
  } cfg_t;

  // One clipped block, ready for the pixel walker.
  typedef struct packed {
    logic [SCREEN_W-1:0]  x0;
    logic [CNT_W-1:0]     nx;
    logic [CNT_W-1:0]     ny;
    logic [ROW_OFF_W-1:0] row_off;  // first visible row times stride
    logic [FIX_W-1:0]     step;
    logic [FIX_W-1:0]     u;
    logic [FIX_W-1:0]     v;
    logic [ADDR_W-1:0]    tex;
  } desc_t;

  typedef struct packed {
    logic [SCREEN_W-1:0] lo;
    logic [CNT_W-1:0]    cnt;
  } span_t;

  // Intersect [start, start+size) with [0, limit).
  function automatic span_t clip_span(input logic signed [COORD_W-1:0] start,
                                      input logic [CNT_W-1:0] size,
                                      input logic [SCREEN_W-1:0] limit);
    logic signed [COORD_W:0] a;
    logic signed [COORD_W:0] b;
    logic signed [COORD_W:0] lim;
    logic signed [COORD_W:0] diff;
    span_t res;
    a    = (start < 0) ? '0 : {start[COORD_W-1], start};
    b    = {start[COORD_W-1], start} + $signed({{(COORD_W+1-CNT_W){1'b0}}, size});
    lim  = $signed({{(COORD_W+1-SCREEN_W){1'b0}}, limit});
    if (b > lim) begin
      b = lim;
    end
    diff    = b - a;
    res.lo  = a[SCREEN_W-1:0];
    res.cnt = (b > a) ? diff[CNT_W-1:0] : '0;
    return res;
  endfunction

endpackage

// ===== hw/rtl/clipped_texture_block_blit.sv =====
// Clipped texture block blitter: one square block request in, one address word
// per visible pixel out (framebuffer byte address, texel byte address, last flag),
// row-major. The front stage clips a request and a two-entry descriptor queue
// decouples it from the pixel walker, which emits one pixel per cycle while the
// result is taken, after a load step for each descriptor. Blocks clipped away
// entirely give no words. Configuration registers must be written through the
// cfg port only while the block is idle; the block itself does not enforce this.
// Depends on cbb_pkg, cbb_front, cbb_queue and cbb_back.
module clipped_texture_block_blit import cbb_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]               cfg_data_i,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic signed [COORD_W-1:0] block_x_i,
  input  logic signed [COORD_W-1:0] block_y_i,
  input  logic [CNT_W-1:0]          block_size_i,
  input  logic [FIX_W-1:0]          step_i,
  input  logic [FIX_W-1:0]          u_start_i,
  input  logic [FIX_W-1:0]          v_start_i,
  input  logic [ADDR_W-1:0]         texture_base_i,
  input  logic                      pop_i,
  output logic                      empty_o,
  output logic [ADDR_W-1:0]         dest_addr_o,
  output logic [ADDR_W-1:0]         texel_addr_o,
  output logic                      last_o
);

  cfg_t  cfg_q;
  desc_t f_desc, q_desc;
  logic  f_push, q_full, q_pop, q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= SCREEN_W'(640);
      cfg_q.screen_height <= SCREEN_W'(480);
      cfg_q.row_stride    <= STRIDE_W'(640);
      cfg_q.frame_base    <= '0;
      cfg_q.wide_pixels   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // Unknown indexes are dropped.
      unique case (reg_idx_e'(cfg_index_i))
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[SCREEN_W-1:0];
        REG_ROW_STRIDE:    cfg_q.row_stride    <= cfg_data_i[STRIDE_W-1:0];
        REG_FRAME_BASE:    cfg_q.frame_base    <= cfg_data_i[ADDR_W-1:0];
        REG_WIDE_PIXELS:   cfg_q.wide_pixels   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  cbb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .push_i         (push_i),
    .full_o         (full_o),
    .block_x_i      (block_x_i),
    .block_y_i      (block_y_i),
    .block_size_i   (block_size_i),
    .step_i         (step_i),
    .u_start_i      (u_start_i),
    .v_start_i      (v_start_i),
    .texture_base_i (texture_base_i),
    .q_push_o       (f_push),
    .q_full_i       (q_full),
    .q_desc_o       (f_desc)
  );

  cbb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_desc),
    .empty_o (q_empty)
  );

  cbb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_desc_i     (q_desc),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .dest_addr_o  (dest_addr_o),
    .texel_addr_o (texel_addr_o),
    .last_o       (last_o)
  );

endmodule

// ===== hw/rtl/cbb_front.sv =====
// Front stage: takes a block request, clips it to the screen and computes the
// first row offset. Depends on cbb_pkg.
module cbb_front import cbb_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic signed [COORD_W-1:0]  block_x_i,
  input  logic signed [COORD_W-1:0]  block_y_i,
  input  logic [CNT_W-1:0]           block_size_i,
  input  logic [FIX_W-1:0]           step_i,
  input  logic [FIX_W-1:0]           u_start_i,
  input  logic [FIX_W-1:0]           v_start_i,
  input  logic [ADDR_W-1:0]          texture_base_i,
  output logic                       q_push_o,
  input  logic                       q_full_i,
  output desc_t                      q_desc_o
);

  logic                      valid_q, valid_d;
  logic signed [COORD_W-1:0] bx_q, by_q;
  logic [CNT_W-1:0]          size_q;
  logic [FIX_W-1:0]          step_q, u_q, v_q;
  logic [ADDR_W-1:0]         tex_q;
  logic [CNT_W-1:0]          size_sat;
  span_t                     xs, ys;
  logic                      visible, accept, leave;

  assign size_sat = (size_q > CNT_W'(MAX_BLOCK_SIZE)) ? CNT_W'(MAX_BLOCK_SIZE) : size_q;
  assign xs       = clip_span(bx_q, size_sat, cfg_i.screen_width);
  assign ys       = clip_span(by_q, size_sat, cfg_i.screen_height);
  assign visible  = (xs.cnt != '0) && (ys.cnt != '0);

  // Drop blocks clipped away entirely without touching the queue.
  assign leave    = valid_q && (!visible || !q_full_i);
  assign q_push_o = valid_q && visible && !q_full_i;
  assign full_o   = valid_q && !leave;
  assign accept   = push_i && !full_o;

  always_comb begin
    q_desc_o.x0      = xs.lo;
    q_desc_o.nx      = xs.cnt;
    q_desc_o.ny      = ys.cnt;
    q_desc_o.row_off = ROW_OFF_W'(ys.lo) * ROW_OFF_W'(cfg_i.row_stride);
    q_desc_o.step    = step_q;
    q_desc_o.u       = u_q;
    q_desc_o.v       = v_q;
    q_desc_o.tex     = tex_q;
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (leave) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bx_q   <= block_x_i;
      by_q   <= block_y_i;
      size_q <= block_size_i;
      step_q <= step_i;
      u_q    <= u_start_i;
      v_q    <= v_start_i;
      tex_q  <= texture_base_i;
    end
  end

endmodule

// ===== hw/rtl/cbb_queue.sv =====
// Short descriptor queue between the front stage and the pixel walker.
// Depends on cbb_pkg.
module cbb_queue import cbb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output desc_t rdata_o,
  output logic  empty_o
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QDEPTH + 1);

  desc_t             mem_q [QDEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CNT_QW-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_QW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wrap_inc(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= wrap_inc(rptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/cbb_back.sv =====
// Pixel walker: steps through one clipped block per descriptor and emits one
// address word per visible pixel through an output register. Depends on cbb_pkg.
module cbb_back import cbb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  desc_t              q_desc_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [ADDR_W-1:0]  dest_addr_o,
  output logic [ADDR_W-1:0]  texel_addr_o,
  output logic               last_o
);

  back_state_e         state_q, state_d;
  logic [FIX_W-1:0]    u_q, v_q, step_q;
  logic [ADDR_W-1:0]   tex_q, row_addr_q;
  logic [SCREEN_W-1:0] x0_q, col_q;
  logic [CNT_W-1:0]    nx_q, ny_q, ccnt_q, rcnt_q;
  logic                out_valid_q;
  logic [ADDR_W-1:0]   dest_q, texel_q;
  logic                last_q;

  logic                load, adv, last_col, last_row;
  logic [FIX_W-1:0]    u_next;
  logic [IDX_W-1:0]    idx;
  logic [ADDR_W-1:0]   dest_d, texel_d;

  assign last_col = (ccnt_q == nx_q - 1'b1);
  assign last_row = (rcnt_q == ny_q - 1'b1);

  // Row bits sit above the column bits, so the index is a plain concatenation.
  assign u_next  = u_q + step_q;
  assign idx     = {v_q[FRAC_BITS+TEX_LOG2-1:FRAC_BITS], u_next[FRAC_BITS+TEX_LOG2-1:FRAC_BITS]};
  assign dest_d  = row_addr_q + (ADDR_W'(col_q) << cfg_i.wide_pixels);
  assign texel_d = tex_q + (ADDR_W'(idx) << cfg_i.wide_pixels);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv && last_col && last_row) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    adv  = 1'b0;
    unique case (state_q)
      ST_IDLE: load = !q_empty_i;
      ST_RUN:  adv  = !out_valid_q || pop_i;
      default: ;
    endcase
  end

  assign q_pop_o      = load;
  assign empty_o      = !out_valid_q;
  assign dest_addr_o  = dest_q;
  assign texel_addr_o = texel_q;
  assign last_o       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      u_q        <= q_desc_i.u;
      v_q        <= q_desc_i.v;
      step_q     <= q_desc_i.step;
      tex_q      <= q_desc_i.tex;
      row_addr_q <= cfg_i.frame_base + ADDR_W'(q_desc_i.row_off);
      x0_q       <= q_desc_i.x0;
      col_q      <= q_desc_i.x0;
      nx_q       <= q_desc_i.nx;
      ny_q       <= q_desc_i.ny;
      ccnt_q     <= '0;
      rcnt_q     <= '0;
    end else if (adv) begin
      u_q     <= u_next;
      dest_q  <= dest_d;
      texel_q <= texel_d;
      last_q  <= last_col && last_row;
      if (last_col) begin
        // Wrap to the next row; u keeps running.
        ccnt_q     <= '0;
        col_q      <= x0_q;
        rcnt_q     <= rcnt_q + 1'b1;
        v_q        <= v_q + step_q;
        row_addr_q <= row_addr_q + ADDR_W'(cfg_i.row_stride);
      end else begin
        ccnt_q <= ccnt_q + 1'b1;
        col_q  <= col_q + 1'b1;
      end
    end
  end

endmodule
